>>> hdl/diff_drive_odometry_macros.svh
// Assertion macros used by the odometry top-level RTL file.
`ifndef DIFF_DRIVE_ODOMETRY_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define DDO_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define DDO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DDO_ASSERT_IMP(label, ante, cons, msg)
`define DDO_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> hdl/ddo_pkg.sv
// Types, constants and helper functions of the odometry block.
`default_nettype none
package ddo_pkg;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_GAIN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_TIME     = 2'd2;
    localparam logic [15:0] TURN_GAIN_RESET = 16'd327;
    localparam logic [15:0] STEP_TIME_RESET = 16'd655;

    // Request kinds.
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_GYRO = 2'd1;
    localparam logic [1:0] REQ_FIX  = 2'd2;

    // CORDIC constants: inverse gain in Q30, angles in Q32 turns.
    localparam int CORDIC_TABLE_LEN = 24;
    localparam int CORDIC_IDX_W     = 5;
    localparam int SINCOS_W         = 27;
    localparam logic signed [31:0] CORDIC_INV_GAIN = 32'sd652032874;

    // Binary angle units per radian in Q16, split into two 16-bit halves.
    localparam logic [15:0] BA_PER_RAD_HI = 16'h28BE;
    localparam logic [15:0] BA_PER_RAD_LO = 16'h60DC;

    // Rounding offsets preloaded into the accumulator.
    localparam logic [63:0] RND_NONE = 64'h0;
    localparam logic [63:0] RND_Q8   = 64'h0000_0000_0000_0080;
    localparam logic [63:0] RND_Q24  = 64'h0000_0000_0080_0000;
    localparam logic [63:0] RND_Q40  = 64'h0000_0080_0000_0000;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic [15:0]        heading_in;
        logic signed [23:0] fix_x;
        logic signed [23:0] fix_y;
    } ddo_req_t;

    typedef struct packed {
        logic [15:0]        heading_out;
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic signed [15:0] speed_out;
        logic signed [23:0] turn_rate_out;
    } ddo_rsp_t;

    typedef struct packed {
        logic signed [SINCOS_W-1:0] sin_val;
        logic signed [SINCOS_W-1:0] cos_val;
    } ddo_sincos_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ddo_cordic_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_WB,
        ST_SINCOS,
        ST_FINISH
    } ddo_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ITER,
        CS_ROUND
    } ddo_cordic_state_t;

    // Multiply-accumulate steps of one speed tick, in issue order.
    typedef enum logic [3:0] {
        OP_W,
        OP_LW,
        OP_CV,
        OP_SLW,
        OP_SV,
        OP_CLW,
        OP_DXT,
        OP_DYT,
        OP_WT,
        OP_QKH,
        OP_QKL
    } ddo_op_t;

    typedef struct packed {
        logic        clear;
        logic        neg;
        logic        shift16;
        logic        wb;
        logic [63:0] rnd_const;
    } ddo_opctl_t;

    function automatic ddo_opctl_t op_ctl(input ddo_op_t op);
        ddo_opctl_t c;
        c = '0;
        case (op)
            OP_W:   begin c.clear = 1'b1; c.wb = 1'b1; c.rnd_const = RND_NONE; end
            OP_LW:  begin c.clear = 1'b1; c.wb = 1'b1; c.rnd_const = RND_NONE; end
            OP_CV:  begin c.clear = 1'b1; c.shift16 = 1'b1; c.rnd_const = RND_Q24; end
            OP_SLW: begin c.neg = 1'b1; c.wb = 1'b1; end
            OP_SV:  begin c.clear = 1'b1; c.shift16 = 1'b1; c.rnd_const = RND_Q24; end
            OP_CLW: begin c.wb = 1'b1; end
            OP_DXT: begin c.clear = 1'b1; c.wb = 1'b1; c.rnd_const = RND_Q24; end
            OP_DYT: begin c.clear = 1'b1; c.wb = 1'b1; c.rnd_const = RND_Q24; end
            OP_WT:  begin c.clear = 1'b1; c.wb = 1'b1; c.rnd_const = RND_Q8; end
            OP_QKH: begin c.clear = 1'b1; c.shift16 = 1'b1; c.rnd_const = RND_Q40; end
            OP_QKL: begin c.wb = 1'b1; end
            default: c = '0;
        endcase
        return c;
    endfunction

    // Arctangent of 2^-i in Q32 turns.
    function automatic logic [31:0] atan_turn(input logic [CORDIC_IDX_W-1:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

>>> hdl/ddo_stream_if.sv
// Valid/ready stream interface used for the request and result channels.
`default_nettype none
interface ddo_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/ddo_cordic.sv
// Iterative rotation-mode CORDIC giving sine and cosine of a binary angle.
`default_nettype none
module ddo_cordic #(
    parameter int STEPS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [15:0]               angle,
    output ddo_pkg::ddo_sincos_t      result,
    output ddo_pkg::ddo_cordic_stat_t stat
);
    import ddo_pkg::*;

    localparam int Active = (STEPS > CORDIC_TABLE_LEN) ? CORDIC_TABLE_LEN : STEPS;
    localparam logic [CORDIC_IDX_W-1:0] LastIdx = CORDIC_IDX_W'(Active - 1);

    ddo_cordic_state_t state_reg, state_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [31:0] z_reg, z_next;
    logic               flip_reg, flip_next;
    logic [CORDIC_IDX_W-1:0] idx_reg, idx_next;
    logic signed [SINCOS_W-1:0] sin_reg, sin_next;
    logic signed [SINCOS_W-1:0] cos_reg, cos_next;
    logic               done_reg, done_next;

    logic               fold;
    logic signed [31:0] x_shift;
    logic signed [31:0] y_shift;
    logic signed [31:0] atan_v;
    logic [32:0]        x_round;
    logic [32:0]        y_round;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        idx_reg  <= idx_next;
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
    end

    // Angles beyond a quarter turn either way are flipped by half a turn.
    assign fold = ((angle[15:14] == 2'b01) && (angle[13:0] != 14'd0))
                || (angle[15:14] == 2'b10);

    assign x_shift = x_reg >>> idx_reg;
    assign y_shift = y_reg >>> idx_reg;
    assign atan_v  = atan_turn(idx_reg);

    // Round half up to Q24; the flip negation folds into the same adder.
    assign x_round = flip_reg ? (~{x_reg[31], x_reg} + 33'd33) : ({x_reg[31], x_reg} + 33'd32);
    assign y_round = flip_reg ? (~{y_reg[31], y_reg} + 33'd33) : ({y_reg[31], y_reg} + 33'd32);

    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        flip_next  = flip_reg;
        idx_next   = idx_reg;
        sin_next   = sin_reg;
        cos_next   = cos_reg;

        case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    x_next     = CORDIC_INV_GAIN;
                    y_next     = 32'sd0;
                    z_next     = {fold ? ~angle[15] : angle[15], angle[14:0], 16'd0};
                    flip_next  = fold;
                    idx_next   = '0;
                    done_next  = 1'b0;
                    state_next = CS_ITER;
                end
            end
            CS_ITER:
            begin
                if (!z_reg[31])
                begin
                    x_next = x_reg - y_shift;
                    y_next = y_reg + x_shift;
                    z_next = z_reg - atan_v;
                end
                else
                begin
                    x_next = x_reg + y_shift;
                    y_next = y_reg - x_shift;
                    z_next = z_reg + atan_v;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LastIdx)
                begin
                    state_next = CS_ROUND;
                end
            end
            CS_ROUND:
            begin
                cos_next   = x_round[32:6];
                sin_next   = y_round[32:6];
                done_next  = 1'b1;
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign result.sin_val = sin_reg;
    assign result.cos_val = cos_reg;
    assign stat.busy      = (state_reg != CS_IDLE);
    assign stat.done      = done_reg;

endmodule
`default_nettype wire

>>> hdl/diff_drive_odometry.sv
// Top level of the differential-drive odometry pose tracker.
//
//  Channel  Direction  Handshake         Payload
//  -------  ---------  ----------------  ------------------------------------------
//  cfg      in         cfg_we            cfg_index, cfg_data (turn gain, offset, step)
//  req      in         req.valid/ready   req_type, wheel speeds, gyro heading, fix
//  rsp      out        rsp.valid/ready   heading, position, speed, turn rate
//
// For a speed tick request the CORDIC runs one iteration a cycle alongside
// the first two of eleven steps on the single shared 36 x 27 multiplier,
// each a multiply and an accumulate state, most of them with a write-back
// state.
// Gyro, fix and unknown requests go straight from idle to the finish step.
// req.ready is high only while the sequencer is idle; a finished result waits in
// the output register, so a new request is taken while rsp is stalled.
// Reset is asynchronous and active low; it clears the pose and loads the
// register defaults.
`default_nettype none
`include "diff_drive_odometry_macros.svh"
module diff_drive_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ddo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ddo_pkg::CFG_DATA_W-1:0]  cfg_data,
    ddo_stream_if.sink                      req,
    ddo_stream_if.source                    rsp
);
    import ddo_pkg::*;

    // Configuration registers.
    logic [15:0] turn_gain_reg, turn_gain_next;
    logic [9:0]  offset_reg, offset_next;
    logic [15:0] step_time_reg, step_time_next;

    // Pose and last motion.
    logic [15:0]        heading_reg, heading_next;
    logic signed [31:0] pos_x_reg, pos_x_next;
    logic signed [31:0] pos_y_reg, pos_y_next;
    logic signed [15:0] last_speed_reg, last_speed_next;
    logic signed [23:0] last_turn_reg, last_turn_next;

    // Sequencer and result register.
    ddo_state_t state_reg, state_next;
    ddo_op_t    op_reg, op_next;
    logic       rsp_valid_reg, rsp_valid_next;
    ddo_rsp_t   rsp_data_reg, rsp_data_next;

    // Working values of one tick.
    logic signed [15:0] v_reg, v_next;
    logic signed [16:0] d_reg, d_next;
    logic signed [23:0] w_reg, w_next;
    logic signed [33:0] lw_reg, lw_next;
    logic signed [35:0] dx_reg, dx_next;
    logic signed [35:0] dy_reg, dy_next;
    logic signed [31:0] q_reg, q_next;
    logic signed [62:0] prod_reg, prod_next;
    logic [63:0]        acc_reg, acc_next;

    logic               req_ready;
    logic               cordic_start;
    ddo_sincos_t        sc;
    ddo_cordic_stat_t   cstat;
    ddo_opctl_t         ctl;
    logic signed [35:0] a_op;
    logic signed [26:0] b_op;
    logic [63:0]        ext;
    logic [63:0]        shifted;
    logic [63:0]        acc_sum;
    logic [16:0]        speed_sum;
    logic [16:0]        speed_diff;

    // Saturate a 41-bit sum of position and step to 32 bits.
    function automatic logic [31:0] sat32(input logic [40:0] s);
        logic [31:0] r;
        if ((&s[40:31]) || (~|s[40:31]))
        begin
            r = s[31:0];
        end
        else if (s[40])
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_start),
        .angle  (heading_reg),
        .result (sc),
        .stat   (cstat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_gain_reg  <= TURN_GAIN_RESET;
            offset_reg     <= '0;
            step_time_reg  <= STEP_TIME_RESET;
            heading_reg    <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            last_speed_reg <= '0;
            last_turn_reg  <= '0;
            state_reg      <= ST_IDLE;
            op_reg         <= OP_W;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            turn_gain_reg  <= turn_gain_next;
            offset_reg     <= offset_next;
            step_time_reg  <= step_time_next;
            heading_reg    <= heading_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            last_speed_reg <= last_speed_next;
            last_turn_reg  <= last_turn_next;
            state_reg      <= state_next;
            op_reg         <= op_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
        v_reg        <= v_next;
        d_reg        <= d_next;
        w_reg        <= w_next;
        lw_reg       <= lw_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        q_reg        <= q_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
    end

    // Configuration writes; an index beyond the register list is dropped.
    always_comb
    begin
        turn_gain_next = turn_gain_reg;
        offset_next    = offset_reg;
        step_time_next = step_time_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TURN_GAIN:     turn_gain_next = cfg_data;
                CFG_OFFSET_LENGTH: offset_next    = cfg_data[9:0];
                CFG_STEP_TIME:     step_time_next = cfg_data;
                default:           ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        a_op = '0;
        b_op = '0;
        case (op_reg)
            OP_W:
            begin
                a_op = {{19{d_reg[16]}}, d_reg};
                b_op = {11'd0, turn_gain_reg};
            end
            OP_LW:
            begin
                a_op = {{12{w_reg[23]}}, w_reg};
                b_op = {17'd0, offset_reg};
            end
            OP_CV:
            begin
                a_op = {{20{v_reg[15]}}, v_reg};
                b_op = sc.cos_val;
            end
            OP_SLW:
            begin
                a_op = {{2{lw_reg[33]}}, lw_reg};
                b_op = sc.sin_val;
            end
            OP_SV:
            begin
                a_op = {{20{v_reg[15]}}, v_reg};
                b_op = sc.sin_val;
            end
            OP_CLW:
            begin
                a_op = {{2{lw_reg[33]}}, lw_reg};
                b_op = sc.cos_val;
            end
            OP_DXT:
            begin
                a_op = dx_reg;
                b_op = {11'd0, step_time_reg};
            end
            OP_DYT:
            begin
                a_op = dy_reg;
                b_op = {11'd0, step_time_reg};
            end
            OP_WT:
            begin
                a_op = {{12{w_reg[23]}}, w_reg};
                b_op = {11'd0, step_time_reg};
            end
            OP_QKH:
            begin
                a_op = {{4{q_reg[31]}}, q_reg};
                b_op = {11'd0, BA_PER_RAD_HI};
            end
            OP_QKL:
            begin
                a_op = {{4{q_reg[31]}}, q_reg};
                b_op = {11'd0, BA_PER_RAD_LO};
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    // The accumulator either restarts at a rounding offset or keeps its sum;
    // a subtraction is an inverted addend with a carry in.
    assign ctl     = op_ctl(op_reg);
    assign ext     = {prod_reg[62], prod_reg};
    assign shifted = ctl.shift16 ? {ext[47:0], 16'd0} : ext;
    assign acc_sum = (ctl.clear ? ctl.rnd_const : acc_reg)
                   + (ctl.neg ? ~shifted : shifted)
                   + {63'd0, ctl.neg};

    assign speed_sum  = {req.payload.left_speed[15], req.payload.left_speed}
                      + {req.payload.right_speed[15], req.payload.right_speed};
    assign speed_diff = {req.payload.right_speed[15], req.payload.right_speed}
                      - {req.payload.left_speed[15], req.payload.left_speed};

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        heading_next    = heading_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        last_speed_next = last_speed_reg;
        last_turn_next  = last_turn_reg;
        v_next          = v_reg;
        d_next          = d_reg;
        w_next          = w_reg;
        lw_next         = lw_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        q_next          = q_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        req_ready       = 1'b0;
        cordic_start    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    case (req.payload.req_type)
                        REQ_TICK:
                        begin
                            v_next       = speed_sum[16:1];
                            d_next       = speed_diff;
                            cordic_start = 1'b1;
                            op_next      = OP_W;
                            state_next   = ST_MUL;
                        end
                        REQ_GYRO:
                        begin
                            heading_next = req.payload.heading_in;
                            state_next   = ST_FINISH;
                        end
                        REQ_FIX:
                        begin
                            pos_x_next = {req.payload.fix_x, 8'd0};
                            pos_y_next = {req.payload.fix_y, 8'd0};
                            state_next = ST_FINISH;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                prod_next  = a_op * b_op;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next = acc_sum;
                if (ctl.wb)
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    op_next    = ddo_op_t'(op_reg + 4'd1);
                    state_next = ST_MUL;
                end
            end
            ST_WB:
            begin
                op_next    = ddo_op_t'(op_reg + 4'd1);
                state_next = ST_MUL;
                case (op_reg)
                    OP_W:
                    begin
                        // Turn rate saturates to 24 bits.
                        if ((&acc_reg[63:23]) || (~|acc_reg[63:23]))
                        begin
                            w_next = acc_reg[23:0];
                        end
                        else if (acc_reg[63])
                        begin
                            w_next = 24'h80_0000;
                        end
                        else
                        begin
                            w_next = 24'h7F_FFFF;
                        end
                    end
                    OP_LW:
                    begin
                        lw_next    = acc_reg[33:0];
                        state_next = ST_SINCOS;
                    end
                    OP_SLW: dx_next = acc_reg[59:24];
                    OP_CLW: dy_next = acc_reg[59:24];
                    OP_DXT:
                    begin
                        pos_x_next = sat32({{9{pos_x_reg[31]}}, pos_x_reg}
                                         + {acc_reg[63], acc_reg[63:24]});
                    end
                    OP_DYT:
                    begin
                        pos_y_next = sat32({{9{pos_y_reg[31]}}, pos_y_reg}
                                         + {acc_reg[63], acc_reg[63:24]});
                    end
                    OP_WT: q_next = acc_reg[39:8];
                    OP_QKL:
                    begin
                        // The heading wraps; the move above used the old one.
                        heading_next    = heading_reg + acc_reg[55:40];
                        last_speed_next = v_reg;
                        last_turn_next  = w_reg;
                        state_next      = ST_FINISH;
                    end
                    default: ;
                endcase
            end
            ST_SINCOS:
            begin
                if (cstat.done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_data_next.heading_out   = heading_reg;
                    rsp_data_next.pos_x_out     = pos_x_reg;
                    rsp_data_next.pos_y_out     = pos_y_reg;
                    rsp_data_next.speed_out     = last_speed_reg;
                    rsp_data_next.turn_rate_out = last_turn_reg;
                    rsp_valid_next              = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req.ready   = req_ready;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    // The products with sine and cosine only start once the CORDIC has finished.
    `DDO_ASSERT_IMP(a_sincos_ready, (state_reg == ST_MUL) && (op_reg == OP_CV), cstat.done, "sine and cosine used before the CORDIC finished")
    // A new rotation never starts on top of one still running.
    `DDO_ASSERT_IMP(a_cordic_free, cordic_start, !cstat.busy, "CORDIC started while busy")
    // A result appears only when the sequencer completes a request.
    `DDO_ASSERT_IMP(a_rsp_from_finish, $rose(rsp_valid_reg), $past(state_reg == ST_FINISH), "result raised outside the finish step")
    // A finished request waits while the previous result is still stalled.
    `DDO_ASSERT_NEXT(a_finish_holds, (state_reg == ST_FINISH) && rsp_valid_reg && !rsp.ready, state_reg == ST_FINISH, "finish step left while output stalled")

endmodule
`default_nettype wire
